>>> rtl/rsam_pkg.sv
package rsam_pkg;

  localparam int unsigned MaxMembers = 16;
  localparam int unsigned SectorBits = 48;
  localparam int unsigned MidxW      = $clog2(MaxMembers);
  localparam int unsigned MemCntW    = 5;
  localparam int unsigned LogW       = 5;
  localparam int unsigned StepCntW   = $clog2(SectorBits + 1);
  localparam int unsigned PaddrW     = 3;
  localparam int unsigned PdataW     = 32;

  localparam logic [LogW-1:0]    ChunkLog2Min   = LogW'(3);
  localparam logic [LogW-1:0]    ChunkLog2Max   = LogW'(20);
  localparam logic [LogW-1:0]    ChunkLog2Reset = LogW'(3);
  localparam logic [MemCntW-1:0] MemberCntReset = MemCntW'(1);
  localparam logic [MemCntW-1:0] MemberCntMax   = MemCntW'(MaxMembers);

  localparam logic [1:0] CMD_MAP    = 2'd0;
  localparam logic [1:0] CMD_SYNCED = 2'd1;
  localparam logic [1:0] CMD_FAILED = 2'd2;

  localparam logic REG_CHUNK_LOG2   = 1'b0;
  localparam logic REG_MEMBER_COUNT = 1'b1;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/rsam_div.sv
module rsam_div
  import rsam_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  div_ctrl_t             ctrl_i,
  input  logic [SectorBits-1:0] dividend_i,
  input  logic [MemCntW-1:0]    divisor_i,
  output div_stat_t             stat_o,
  output logic [SectorBits-1:0] quotient_o,
  output logic [MemCntW-1:0]    remainder_o
);

  logic [SectorBits-1:0] quot_q, quot_d;
  logic [MemCntW-1:0]    rem_q, rem_d;
  logic [StepCntW-1:0]   cnt_q, cnt_d;
  logic                  run_q, run_d;
  logic                  done_q, done_d;
  logic [MemCntW:0]      trial;
  logic                  fits;

  assign trial = {rem_q, quot_q[SectorBits-1]};
  assign fits  = trial >= {1'b0, divisor_i};

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = done_q;
    if (ctrl_i.start) begin
      quot_d = dividend_i;
      rem_d  = '0;
      cnt_d  = StepCntW'(SectorBits);
      run_d  = 1'b1;
      done_d = 1'b0;
    end else if (run_q) begin
      rem_d  = fits ? MemCntW'(trial - {1'b0, divisor_i}) : MemCntW'(trial);
      quot_d = {quot_q[SectorBits-2:0], fits};
      cnt_d  = cnt_q - StepCntW'(1);
      if (cnt_q == StepCntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign stat_o.busy  = run_q;
  assign stat_o.done  = done_q;
  assign quotient_o   = quot_q;
  assign remainder_o  = rem_q;

endmodule

>>> rtl/raid0_stripe_address_mapper.sv
// RAID-0 stripe address mapper. A map request (command 0) splits the logical
// sector into chunk number and offset, divides the chunk number by the member
// count in a single restoring divider that retires one quotient bit per cycle,
// and returns the member index and member sector once the divide steps finish
// and the result is loaded, which waits for a free output register; the next
// item is accepted only when the block is idle and its output is free.
// Synced and failed events update the active-member mask and the optimal flag
// and give their result in the cycle after the transfer. One item is in
// flight at a time.
// Registers: chunk_sectors_log2 at 0x0 (saturated to 3..20), member_count at
// 0x4 (0 acts as 1, above 16 acts as 16); write only while idle.
module raid0_stripe_address_mapper
  import rsam_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PaddrW-1:0]     paddr,
  input  logic [PdataW-1:0]     pwdata,
  output logic [PdataW-1:0]     prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            command_i,
  input  logic [SectorBits-1:0] logical_sector_i,
  input  logic [MidxW-1:0]      member_select_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [MidxW-1:0]      member_index_o,
  output logic [SectorBits-1:0] member_sector_o,
  output logic                  rejected_o,
  output logic                  array_optimal_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } state_e;

  state_e                state_q, state_d;
  logic [LogW-1:0]       chunk_log2_q;
  logic [MemCntW-1:0]    member_cnt_q;
  logic [MaxMembers-1:0] active_q, active_d;
  logic                  optimal_q, optimal_d;
  logic [SectorBits-1:0] sector_q;

  logic                  out_valid_q, out_valid_d;
  logic [MidxW-1:0]      out_idx_q, out_idx_d;
  logic [SectorBits-1:0] out_sec_q, out_sec_d;
  logic                  out_rej_q, out_rej_d;

  logic                  cfg_wr;
  logic [LogW-1:0]       eff_log2;
  logic [MemCntW-1:0]    eff_members;
  logic [MaxMembers-1:0] need_mask;
  logic [MaxMembers-1:0] sel_bit;
  logic                  sel_ok;
  logic                  out_free;
  logic                  accept;
  logic [SectorBits-1:0] offset_mask;
  logic [SectorBits-1:0] mapped_sector;
  logic [MidxW-1:0]      mapped_idx;

  div_ctrl_t             div_ctrl;
  div_stat_t             div_stat;
  logic [SectorBits-1:0] div_quot;
  logic [MemCntW-1:0]    div_rem;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      REG_CHUNK_LOG2:   prdata = PdataW'(chunk_log2_q);
      REG_MEMBER_COUNT: prdata = PdataW'(member_cnt_q);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_log2_q <= ChunkLog2Reset;
      member_cnt_q <= MemberCntReset;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_CHUNK_LOG2) begin
        chunk_log2_q <= pwdata[LogW-1:0];
      end else begin
        member_cnt_q <= pwdata[MemCntW-1:0];
      end
    end
  end

  always_comb begin
    eff_log2 = chunk_log2_q;
    if (chunk_log2_q < ChunkLog2Min) eff_log2 = ChunkLog2Min;
    if (chunk_log2_q > ChunkLog2Max) eff_log2 = ChunkLog2Max;
    eff_members = member_cnt_q;
    if (member_cnt_q == '0) eff_members = MemCntW'(1);
    if (member_cnt_q > MemberCntMax) eff_members = MemberCntMax;
  end

  assign need_mask = MaxMembers'(({{MaxMembers{1'b0}}, 1'b1} << eff_members)
                     - {{MaxMembers{1'b0}}, 1'b1});
  assign sel_bit   = MaxMembers'(1) << member_select_i;
  assign sel_ok    = {1'b0, member_select_i} < eff_members;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  assign div_ctrl.start = accept && (command_i == CMD_MAP);

  rsam_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (div_ctrl),
    .dividend_i  (logical_sector_i >> eff_log2),
    .divisor_i   (eff_members),
    .stat_o      (div_stat),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  assign offset_mask   = (SectorBits'(1) << eff_log2) - SectorBits'(1);
  assign mapped_sector = (div_quot << eff_log2) | (sector_q & offset_mask);
  assign mapped_idx    = MidxW'(div_rem);

  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    optimal_d   = optimal_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_idx_d   = out_idx_q;
    out_sec_d   = out_sec_q;
    out_rej_d   = out_rej_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (command_i)
            CMD_MAP: begin
              state_d = ST_BUSY;
            end
            CMD_SYNCED, CMD_FAILED: begin
              if (sel_ok) begin
                active_d = (command_i == CMD_SYNCED) ? (active_q | sel_bit)
                                                     : (active_q & ~sel_bit);
              end
              optimal_d   = (active_d & need_mask) == need_mask;
              out_valid_d = 1'b1;
              out_idx_d   = member_select_i;
              out_sec_d   = '0;
              out_rej_d   = !sel_ok;
            end
            default: begin
              out_valid_d = 1'b1;
              out_idx_d   = '0;
              out_sec_d   = '0;
              out_rej_d   = 1'b1;
            end
          endcase
        end
      end
      ST_BUSY: begin
        if (div_stat.done && !div_stat.busy && out_free) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          out_idx_d   = mapped_idx;
          out_sec_d   = mapped_sector;
          out_rej_d   = !active_q[mapped_idx];
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= '0;
      optimal_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      optimal_q   <= optimal_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_idx_q <= out_idx_d;
    out_sec_q <= out_sec_d;
    out_rej_q <= out_rej_d;
    if (accept) begin
      sector_q <= logical_sector_i;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign member_index_o  = out_idx_q;
  assign member_sector_o = out_sec_q;
  assign rejected_o      = out_rej_q;
  assign array_optimal_o = optimal_q;

endmodule

>>> rtl/rsam_checker.sv
module rsam_checker
  import rsam_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  pready,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic [1:0]            command_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [MidxW-1:0]      member_index_o,
  input logic [SectorBits-1:0] member_sector_o,
  input logic                  rejected_o
);

  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready dropped");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(member_index_o)
      && $stable(member_sector_o) && $stable(rejected_o))
    else $error("stalled result changed");

  a_map_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && command_i == CMD_MAP |=> !in_ready_o)
    else $error("map request did not occupy the divider");

  a_event_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && command_i != CMD_MAP |=> out_valid_o)
    else $error("event result missing");

endmodule

bind raid0_stripe_address_mapper rsam_checker u_rsam_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .pready          (pready),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .command_i       (command_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .member_index_o  (member_index_o),
  .member_sector_o (member_sector_o),
  .rejected_o      (rejected_o)
);

>>> dv/tb_raid0_stripe_address_mapper.sv
module tb_raid0_stripe_address_mapper;
  import rsam_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CmdUnknown = 2'd3;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned PhaseItems = 190;
  localparam int unsigned NumPhases = 8;

  typedef struct packed {
    logic [MidxW-1:0]      member_index;
    logic [SectorBits-1:0] member_sector;
    logic                  rejected;
    logic                  array_optimal;
  } map_result_t;

  class stripe_map_predictor;
    logic [LogW-1:0]       chunk_log2;
    logic [MemCntW-1:0]    member_count;
    logic [MaxMembers-1:0] active_members;
    logic                  optimal;
    map_result_t           expected_maps[$];
    int unsigned           mismatches;

    function new();
      chunk_log2 = ChunkLog2Reset;
      member_count = MemberCntReset;
      active_members = '0;
      optimal = 1'b0;
      mismatches = 0;
    endfunction

    function void set_reg(logic idx, logic [MemCntW-1:0] value);
      if (idx == REG_CHUNK_LOG2) begin
        chunk_log2 = value;
      end else begin
        member_count = value;
      end
    endfunction

    function int unsigned eff_members();
      if (member_count == '0) return 1;
      if (member_count > MemberCntMax) return MaxMembers;
      return member_count;
    endfunction

    function int unsigned eff_log2();
      if (chunk_log2 < ChunkLog2Min) return ChunkLog2Min;
      if (chunk_log2 > ChunkLog2Max) return ChunkLog2Max;
      return chunk_log2;
    endfunction

    function void note_item(logic [1:0] cmd, logic [SectorBits-1:0] sector,
                            logic [MidxW-1:0] sel);
      map_result_t           r;
      int unsigned           lg;
      int unsigned           m;
      logic [63:0]           piece;
      logic [63:0]           offs;
      logic [63:0]           quo;
      logic [MaxMembers-1:0] need;
      r = '0;
      m = eff_members();
      if (cmd == CMD_MAP) begin
        lg = eff_log2();
        piece = 64'(sector) >> lg;
        offs = 64'(sector) & ((64'd1 << lg) - 64'd1);
        quo = piece / m;
        r.member_index = MidxW'(piece % m);
        r.member_sector = SectorBits'((quo << lg) + offs);
        r.rejected = !active_members[r.member_index];
      end else if (cmd == CMD_SYNCED || cmd == CMD_FAILED) begin
        r.member_index = sel;
        if (sel < m) begin
          active_members[sel] = (cmd == CMD_SYNCED);
        end else begin
          r.rejected = 1'b1;
        end
        need = MaxMembers'((17'd1 << m) - 17'd1);
        optimal = ((active_members & need) == need);
      end else begin
        r.rejected = 1'b1;
      end
      r.array_optimal = optimal;
      expected_maps.push_back(r);
    endfunction

    function void check_result(map_result_t got);
      map_result_t want;
      if (expected_maps.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        mismatches++;
        return;
      end
      want = expected_maps.pop_front();
      if (got.member_index !== want.member_index) begin
        $display("%0t: member_index expected %0d actual %0d",
                 $time, want.member_index, got.member_index);
        mismatches++;
      end
      if (got.member_sector !== want.member_sector) begin
        $display("%0t: member_sector expected 0x%h actual 0x%h",
                 $time, want.member_sector, got.member_sector);
        mismatches++;
      end
      if (got.rejected !== want.rejected) begin
        $display("%0t: rejected expected %0b actual %0b",
                 $time, want.rejected, got.rejected);
        mismatches++;
      end
      if (got.array_optimal !== want.array_optimal) begin
        $display("%0t: array_optimal expected %0b actual %0b",
                 $time, want.array_optimal, got.array_optimal);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_maps.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PaddrW-1:0]     paddr;
  logic [PdataW-1:0]     pwdata;
  logic [PdataW-1:0]     prdata;
  logic                  pready;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [1:0]            command_i;
  logic [SectorBits-1:0] logical_sector_i;
  logic [MidxW-1:0]      member_select_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [MidxW-1:0]      member_index_o;
  logic [SectorBits-1:0] member_sector_o;
  logic                  rejected_o;
  logic                  array_optimal_o;

  stripe_map_predictor mapper_sb;
  int unsigned         tx_idle_pct;
  int unsigned         rx_idle_pct;
  int unsigned         hold_left;
  int unsigned         stall_cycles;

  raid0_stripe_address_mapper dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .logical_sector_i (logical_sector_i),
    .member_select_i  (member_select_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .member_index_o   (member_index_o),
    .member_sector_o  (member_sector_o),
    .rejected_o       (rejected_o),
    .array_optimal_o  (array_optimal_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // hold off the receiver while a stall is pending, else drop ready at random
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      mapper_sb.check_result('{member_index_o, member_sector_o, rejected_o,
                               array_optimal_o});
    end
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [MemCntW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'({idx, 2'b00});
    pwdata  <= PdataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    mapper_sb.set_reg(idx, value);
  endtask

  task automatic configure(logic [LogW-1:0] lg, logic [MemCntW-1:0] members);
    write_reg(REG_CHUNK_LOG2, lg);
    write_reg(REG_MEMBER_COUNT, members);
  endtask

  task automatic send_item(logic [1:0] cmd, logic [SectorBits-1:0] sector,
                           logic [MidxW-1:0] sel);
    int unsigned gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    command_i        <= cmd;
    logical_sector_i <= sector;
    member_select_i  <= sel;
    do @(posedge clk_i); while (!in_ready_o);
    mapper_sb.note_item(cmd, sector, sel);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (mapper_sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_item();
    int unsigned           pick;
    int unsigned           m;
    logic [1:0]            cmd;
    logic [SectorBits-1:0] sector;
    logic [MidxW-1:0]      sel;
    m = mapper_sb.eff_members();
    pick = $urandom_range(99);
    sector = SectorBits'({$urandom, $urandom});
    sel = MidxW'($urandom);
    if (pick < 62) begin
      cmd = CMD_MAP;
      pick = $urandom_range(99);
      if (pick < 10) begin
        sector = SectorBits'($urandom_range(255));
      end else if (pick < 20) begin
        sector = SectorBits'($urandom);
      end else if (pick < 24) begin
        sector = '1 - SectorBits'($urandom_range(255));
      end
    end else if (pick < 97) begin
      cmd = (pick < 82) ? CMD_SYNCED : CMD_FAILED;
      if ($urandom_range(99) < 85) sel = MidxW'($urandom_range(m - 1));
    end else begin
      cmd = CmdUnknown;
    end
    send_item(cmd, sector, sel);
  endtask

  initial begin
    logic [LogW-1:0]    phase_lg[NumPhases];
    logic [MemCntW-1:0] phase_members[NumPhases];
    phase_lg      = '{5'd5, 5'd31, 5'd3, 5'd20, 5'd1, 5'd11, 5'd21, 5'd0};
    phase_members = '{5'd4, 5'd17, 5'd16, 5'd1, 5'd31, 5'd3, 5'd0, 5'd7};
    mapper_sb        = new();
    tx_idle_pct      = 25;
    rx_idle_pct      = 56;
    hold_left        = 0;
    stall_cycles     = 0;
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_valid_i       = 1'b0;
    command_i        = CMD_MAP;
    logical_sector_i = '0;
    member_select_i  = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send_item(CMD_MAP, '0, '0);
    send_item(CMD_SYNCED, '0, '0);
    send_item(CMD_MAP, '0, '1);
    send_item(CMD_MAP, '1, '0);
    send_item(CMD_MAP, SectorBits'(7), '0);
    send_item(CMD_MAP, SectorBits'(8), '0);
    send_item(CMD_SYNCED, '1, '0);
    send_item(CMD_SYNCED, '0, MidxW'(5));
    send_item(CMD_FAILED, '0, '0);
    send_item(CMD_FAILED, '0, '0);
    send_item(CMD_FAILED, '0, '1);
    send_item(CmdUnknown, '1, '1);
    send_item(CMD_MAP, SectorBits'(9), '0);
    send_item(CMD_SYNCED, '0, '0);
    drain();

    configure(ChunkLog2Max, MemberCntMax);
    send_item(CMD_SYNCED, '0, '1);
    send_item(CMD_MAP, '1, '0);
    send_item(CMD_MAP, SectorBits'(20'hFFFFF), '0);
    send_item(CMD_MAP, SectorBits'(21'h100000), '0);
    send_item(CMD_FAILED, '0, '1);
    send_item(CMD_MAP, '1, '0);
    send_item(CmdUnknown, '0, '0);
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      if (p == 3) begin
        tx_idle_pct = 56;
        rx_idle_pct = 25;
      end else if (p == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      configure(phase_lg[p], phase_members[p]);
      if (p == 1 || p == 6) hold_left = 600;
      for (int i = 0; i < PhaseItems; i++) random_item();
      drain();
    end

    repeat (60) @(posedge clk_i);
    if (mapper_sb.mismatches == 0 && mapper_sb.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
